>>> rtl/gtpp_pkg.sv
// Shared types, constants and the 3x5 glyph ROM of the glyph tile pixel plotter.
package gtpp_pkg;

  // Glyph ROM geometry.
  localparam int GlyphCount = 96;
  localparam int GlyphRows  = 5;
  localparam int GlyphCols  = 3;
  localparam int GlyphCells = GlyphRows * GlyphCols;

  // Counter and pixel position widths.
  localparam int CtrW = 12;
  localparam int PosW = 13;

  // Character codes with special handling.
  localparam logic [7:0] CodeNewline    = 8'd10;
  localparam logic [6:0] CodeFirstGlyph = 7'd32;

  // Cursor steps.
  localparam logic [CtrW-1:0] CharAdvance = 12'd4;
  localparam logic [CtrW-1:0] LineAdvance = 12'd8;

  // Lower-rows shade: one palette color is lifted on the bottom rows.
  localparam logic [3:0] ShadeColor    = 4'd2;
  localparam logic [3:0] ShadeOffset   = 4'd2;
  localparam logic [2:0] ShadeFirstRow = 3'd3;

  // Configuration register indexes.
  localparam logic [1:0] CfgAreaEnabled = 2'd0;
  localparam logic [1:0] CfgTileBase    = 2'd1;
  localparam logic [1:0] CfgRowTiles    = 2'd2;

  typedef struct packed {
    logic       area_enabled;
    logic [9:0] tile_base;
    logic [5:0] row_tiles;
  } cfg_t;

  // One character's work handed from the front to the back.
  typedef struct packed {
    logic [GlyphCells-1:0] cells;    // cell 0 in the top bit
    logic [PosW-1:0]       px_base;
    logic [PosW-1:0]       py_base;  // drop already included
    logic [3:0]            color;
  } job_t;

  // Bit 15 down to 1: cells row-major from the top left; bit 0: drop one row.
  localparam logic [15:0] GlyphRom [GlyphCount] = '{
    16'h0000, 16'h4904, 16'hb400, 16'hbefa, 16'h7bbc, 16'ha54a, 16'h555c, 16'h4800,
    16'h2922, 16'h4494, 16'h1550, 16'h0ba0, 16'h0028, 16'h0380, 16'h0004, 16'h2548,
    16'h76dc, 16'h592e, 16'hc5ce, 16'hc51c, 16'h92f2, 16'hf39c, 16'h73dc, 16'he548,
    16'h77dc, 16'h779c, 16'h0820, 16'h0828, 16'h2a22, 16'h1c70, 16'h88a8, 16'he504,
    16'h56c6, 16'h77da, 16'h775c, 16'h7246, 16'hd6dc, 16'h73ce, 16'h73c8, 16'h72d6,
    16'hb7da, 16'he92e, 16'h64d4, 16'hb75a, 16'h924e, 16'hbeda, 16'hd6da, 16'h56d4,
    16'hd7c8, 16'h76f6, 16'h775a, 16'h711c, 16'he924, 16'hb6d6, 16'hb6d4, 16'hb6fa,
    16'hb55a, 16'hb524, 16'he54e, 16'h6926, 16'h9112, 16'h6496, 16'h5400, 16'h000e,
    16'h4400, 16'h0ed6, 16'h9adc, 16'h0e46, 16'h2ed6, 16'h0ee6, 16'h5668, 16'h559d,
    16'h935a, 16'h4122, 16'h4129, 16'h975a, 16'h4922, 16'h17da, 16'h1ada, 16'h0ad4,
    16'hd6e9, 16'h76b3, 16'h1748, 16'h0f1c, 16'h9a46, 16'h16d6, 16'h16dc, 16'h16fa,
    16'h155a, 16'hb595, 16'h1cae, 16'h6b26, 16'h4924, 16'hc9ac, 16'h5400, 16'h56f0
  };

endpackage

>>> rtl/gtpp_front.sv
// Front end: accepts characters, keeps the cursor and line offset, looks up glyphs.
module gtpp_front import gtpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // char_code, origin_x, origin_y, color_index, zero pad
  input  logic        s_axis_tuser,  // first_char
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output job_t        push_job_o
);

  logic [CtrW-1:0] cursor_q, cursor_d;
  logic [CtrW-1:0] line_q, line_d;
  logic [CtrW-1:0] cursor_eff, line_eff;
  logic [7:0]      code;
  logic [7:0]      origin_x, origin_y;
  logic [3:0]      color;
  logic            accept, printable, newline;
  logic [15:0]     glyph;

  // Unpack the input word.
  assign code     = s_axis_tdata[7:0];
  assign origin_x = s_axis_tdata[15:8];
  assign origin_y = s_axis_tdata[23:16];
  assign color    = s_axis_tdata[27:24];

  // A character is taken whenever the queue has room, even one that draws nothing.
  assign s_axis_tready = push_ready_i;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // A new string starts from a cleared cursor and line offset.
  assign cursor_eff = s_axis_tuser ? '0 : cursor_q;
  assign line_eff   = s_axis_tuser ? '0 : line_q;

  // Glyph lookup; codes outside the ROM draw a blank glyph.
  assign newline   = (code == CodeNewline);
  assign printable = ~code[7] & (code[6:5] != 2'b00);
  assign glyph     = printable ? GlyphRom[code[6:0] - CodeFirstGlyph] : 16'h0000;

  // Cursor and line offset update.
  always_comb begin
    cursor_d = cursor_q;
    line_d   = line_q;
    if (accept) begin
      cursor_d = cursor_eff;
      line_d   = line_eff;
      if (cfg_i.area_enabled) begin
        if (newline) begin
          cursor_d = '0;
          line_d   = line_eff + LineAdvance;
        end else begin
          cursor_d = cursor_eff + CharAdvance;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      line_q   <= '0;
    end else begin
      cursor_q <= cursor_d;
      line_q   <= line_d;
    end
  end

  // Only characters with lit cells go on to the back end.
  assign push_valid_o = accept & cfg_i.area_enabled & ~newline & (glyph[15:1] != '0);

  always_comb begin
    push_job_o.cells   = glyph[15:1];
    push_job_o.px_base = {5'b0, origin_x} + {1'b0, cursor_eff};
    push_job_o.py_base = {5'b0, origin_y} + {1'b0, line_eff} + {{(PosW-1){1'b0}}, glyph[0]};
    push_job_o.color   = color;
  end

endmodule

>>> rtl/gtpp_queue.sv
// Small queue of glyph jobs between the front and back ends.
module gtpp_queue import gtpp_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full     = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == LastSlot) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == LastSlot) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

>>> rtl/gtpp_back.sv
// Back end: walks a glyph's lit cells; one pixel write per cycle unless the output stalls.
module gtpp_back import gtpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  job_t        pop_job_i,
  output logic        busy_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // tile_index, pixel_x, pixel_y, pixel_color, zero pad
  output logic        m_axis_tlast   // last_write
);

  logic            active_q, active_d;
  job_t            cur_q, cur_d;
  job_t            src;
  logic            out_valid_q, out_valid_d;
  logic [9:0]      tile_q, tile_d;
  logic [2:0]      pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [3:0]      color_q, color_d;
  logic            last_q, last_d;
  logic            advance, have, emit;
  logic [2:0]      sel_row;
  logic [1:0]      sel_col;
  logic [3:0]      sel_bit;
  logic [GlyphCells-1:0] remain;
  logic [PosW-1:0] px, py;
  logic [15:0]     row_prod;

  // The output register moves when empty or when its word is taken.
  assign advance = ~out_valid_q | m_axis_tready;
  assign have    = active_q | pop_valid_i;
  assign emit    = advance & have;
  assign src     = active_q ? cur_q : pop_job_i;
  assign pop_ready_o = advance & ~active_q;
  assign busy_o      = active_q;

  // Pick the first lit cell in reading order.
  always_comb begin
    sel_row = '0;
    sel_col = '0;
    sel_bit = '0;
    for (int r = GlyphRows - 1; r >= 0; r--) begin
      for (int c = GlyphCols - 1; c >= 0; c--) begin
        if (src.cells[GlyphCells - 1 - (r * GlyphCols + c)]) begin
          sel_row = 3'(r);
          sel_col = 2'(c);
          sel_bit = 4'(GlyphCells - 1 - (r * GlyphCols + c));
        end
      end
    end
  end

  assign remain = src.cells & ~(15'(1) << sel_bit);

  // Pixel position and tile address of the chosen cell.
  assign px       = src.px_base + {{(PosW-2){1'b0}}, sel_col};
  assign py       = src.py_base + {{(PosW-3){1'b0}}, sel_row};
  assign row_prod = {6'b0, py[12:3]} * {10'b0, cfg_i.row_tiles};

  always_comb begin
    active_d    = active_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    tile_d      = tile_q;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    color_d     = color_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      active_d    = (remain != '0);
      cur_d       = src;
      cur_d.cells = remain;
      tile_d      = cfg_i.tile_base + row_prod[9:0] + px[12:3];
      pix_x_d     = px[2:0];
      pix_y_d     = py[2:0];
      color_d     = (src.color == ShadeColor && sel_row >= ShadeFirstRow)
                    ? src.color + ShadeOffset : src.color;
      last_d      = (remain == '0);
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    tile_q  <= tile_d;
    pix_x_q <= pix_x_d;
    pix_y_q <= pix_y_d;
    color_q <= color_d;
    last_q  <= last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, color_q, pix_y_q, pix_x_q, tile_q};
  assign m_axis_tlast  = last_q;

endmodule

>>> rtl/glyph_tile_pixel_plotter_unit.sv
// The first pixel write of a character passes the job queue and then the output register.
// The back end emits one pixel write per cycle unless the output stalls, one per lit cell
// (at most 15); characters that draw nothing are taken but not queued.
// The job queue between front and back lets input and output stall on their own.
// Reset clears the cursor, the line offset, the queue and the output register, and sets
// the area disabled, tile base 0 and one tile per row.
module glyph_tile_pixel_plotter_unit import gtpp_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // char_code, origin_x, origin_y, color_index, zero pad
  input  logic        s_axis_tuser,  // first_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // tile_index, pixel_x, pixel_y, pixel_color, zero pad
  output logic        m_axis_tlast   // last_write
);

  cfg_t cfg_q, cfg_d;
  logic push_valid, push_ready, pop_valid, pop_ready, back_busy;
  job_t push_job, pop_job;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgAreaEnabled: cfg_d.area_enabled = cfg_data_i[0];
        CfgTileBase:    cfg_d.tile_base    = cfg_data_i;
        CfgRowTiles:    cfg_d.row_tiles    = cfg_data_i[5:0];
        default:        cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.area_enabled <= 1'b0;
      cfg_q.tile_base    <= '0;
      cfg_q.row_tiles    <= 6'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gtpp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_job_o    (push_job)
  );

  gtpp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  gtpp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_job_i     (pop_job),
    .busy_o        (back_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // While a glyph is partly drawn, the word on the output is a valid, non-final write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_busy |-> (m_axis_tvalid && !m_axis_tlast))
    else $error("glyph in progress without a pending non-final write");

  // With no work queued or in progress, a free output stays empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pop_valid && !back_busy && (!m_axis_tvalid || m_axis_tready)) |=> !m_axis_tvalid)
    else $error("pixel write produced without any queued glyph");

  // A character taken while the area is disabled never reaches the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !cfg_q.area_enabled && !pop_valid) |=> !pop_valid)
    else $error("glyph queued while the text area is disabled");

endmodule
